[design/asd_pkg.sv]
`timescale 1ns / 1ps

package asd_pkg;

  localparam int WINDOW_DEF   = 5;
  localparam int AXES         = 3;
  localparam int SAMPLE_W     = 16;
  localparam int THRESHOLD_W  = 16;
  localparam int PERIOD_W     = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int AXIS_GAP_W   = 16;
  localparam int GLOBAL_GAP_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_PERIOD = 1'd1;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 16'd10;
  localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 8'd10;

  // A trend entry is a two-bit two's complement value of -1, 0 or +1.
  typedef logic [1:0] trend_t;

  localparam trend_t TREND_ZERO = 2'b00;
  localparam trend_t TREND_UP   = 2'b01;
  localparam trend_t TREND_DOWN = 2'b11;

  typedef struct packed {
    logic                   advance;
    logic                   first;
    logic [THRESHOLD_W-1:0] threshold;
    logic [PERIOD_W-1:0]    min_step_period;
  } asd_ctl_t;

endpackage

[design/asd_if.sv]
`timescale 1ns / 1ps

interface asd_sample_if
  import asd_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] accel_x;
  logic signed [SAMPLE_W-1:0] accel_y;
  logic signed [SAMPLE_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface asd_result_if;
  logic valid;
  logic ready;
  logic step_detected;

  modport source (output valid, output step_detected, input ready);
  modport sink (input valid, input step_detected, output ready);
endinterface

[design/accel_step_detector.sv]
`timescale 1ns / 1ps
// Path: an accepted sample is registered in s1, and its result in the result register.
// Throughput: one sample per cycle unless the result stalls; the per-axis window and
// gap updates and the global gap update all close in the single compute stage.
// Reset (synchronous, active high) clears the windows, fill indexes and gap counters,
// rearms first-sample handling, and sets threshold and min_step_period to 10.

module accel_step_detector
  import asd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  asd_sample_if.sink            samples,
  asd_result_if.source          steps
);

  logic [THRESHOLD_W-1:0] threshold;
  logic [PERIOD_W-1:0]    min_step_period;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic signed [SAMPLE_W-1:0] s1_y;
  logic signed [SAMPLE_W-1:0] s1_z;
  logic                       s1_adv;

  logic                     first;
  logic [GLOBAL_GAP_W-1:0]  global_gap;
  logic [GLOBAL_GAP_W-1:0]  gap_inc;
  logic [GLOBAL_GAP_W-1:0]  global_gap_next;
  logic                     step_next;

  logic signed [SAMPLE_W-1:0] axis_sample [AXES];
  logic [AXES-1:0]            axis_hit;
  asd_ctl_t                   ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      min_step_period <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= THRESHOLD_W'(cfg_data);
        REG_MIN_STEP_PERIOD: min_step_period <= PERIOD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign s1_adv = s1_valid && (!steps.valid || steps.ready);
  assign samples.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_x <= samples.accel_x;
      s1_y <= samples.accel_y;
      s1_z <= samples.accel_z;
    end
  end

  assign axis_sample[0] = s1_x;
  assign axis_sample[1] = s1_y;
  assign axis_sample[2] = s1_z;

  assign ctl = '{advance: s1_adv, first: first, threshold: threshold,
                 min_step_period: min_step_period};

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    asd_axis #(
      .WINDOW(WINDOW)
    ) u_axis (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .sample(axis_sample[a]),
      .hit(axis_hit[a])
    );
  end

  always_comb begin
    gap_inc = (global_gap == '1) ? global_gap : global_gap + GLOBAL_GAP_W'(1);
    step_next = (|axis_hit) && (gap_inc > GLOBAL_GAP_W'(min_step_period));
    global_gap_next = step_next ? '0 : gap_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      global_gap <= '0;
      steps.valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        first <= 1'b0;
        global_gap <= global_gap_next;
        steps.valid <= 1'b1;
      end else if (steps.ready) begin
        steps.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      steps.step_detected <= step_next;
    end
  end

  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> steps.valid)
    else $error("computed item did not reach the result register");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> s1_valid)
    else $error("accepted item lost before the compute stage");

  a_step_clears_gap: assert property (@(posedge clk) disable iff (rst)
    s1_adv && step_next |=> global_gap == '0 && steps.step_detected)
    else $error("reported step did not clear the global gap counter");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> !first)
    else $error("first-sample flag survived a computed item");

endmodule

[design/asd_axis.sv]
`timescale 1ns / 1ps

module asd_axis
  import asd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  asd_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       hit
);

  localparam int WLEN   = WINDOW + 2;
  localparam int LAST   = WINDOW + 1;
  localparam int FILL_W = $clog2(WLEN);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] LAST_IDX = FILL_W'(LAST);
  localparam logic [FILL_W-1:0] REFILL   = FILL_W'(2);

  logic signed [SAMPLE_W-1:0] prev;
  trend_t                     win [WLEN];
  logic [FILL_W-1:0]          fill;
  logic [AXIS_GAP_W-1:0]      gap;

  trend_t                     win_next [WLEN];
  logic [FILL_W-1:0]          fill_next;
  logic [AXIS_GAP_W-1:0]      gap_next;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        mag;
  trend_t                   q;
  trend_t                   wa [WLEN];
  logic                     found;
  logic [FILL_W-1:0]        first_diff;
  logic [CNT_W-1:0]         n_zero;
  logic [CNT_W-1:0]         n_up;
  logic [CNT_W-1:0]         n_down;
  trend_t                   pick;
  logic                     pair;
  logic [AXIS_GAP_W-1:0]    gap_inc;

  always_comb begin
    if (ctl.first) begin
      diff = '0;
    end else begin
      diff = {sample[SAMPLE_W-1], sample} - {prev[SAMPLE_W-1], prev};
    end
    mag = diff[SAMPLE_W] ? -diff : diff;
    if (mag > {1'b0, ctl.threshold}) begin
      q = diff[SAMPLE_W] ? TREND_DOWN : TREND_UP;
    end else begin
      q = TREND_ZERO;
    end

    for (int j = 0; j < WLEN; j++) begin
      wa[j] = (fill == FILL_W'(j)) ? q : win[j];
    end

    found = 1'b0;
    first_diff = '0;
    for (int i = 1; i <= WINDOW; i++) begin
      if (!found && wa[i] != wa[0]) begin
        found = 1'b1;
        first_diff = FILL_W'(i);
      end
    end

    n_zero = '0;
    n_up = '0;
    n_down = '0;
    for (int i = 1; i <= WINDOW; i++) begin
      if (wa[i] == TREND_ZERO) begin
        n_zero = n_zero + CNT_W'(1);
      end else if (wa[i] == TREND_UP) begin
        n_up = n_up + CNT_W'(1);
      end else begin
        n_down = n_down + CNT_W'(1);
      end
    end
    if (n_zero > n_up && n_zero > n_down) begin
      pick = TREND_ZERO;
    end else if (n_up > n_zero && n_up > n_down) begin
      pick = TREND_UP;
    end else if (n_down > n_up && n_down > n_zero) begin
      pick = TREND_DOWN;
    end else begin
      pick = wa[LAST];
    end

    win_next = wa;
    fill_next = fill + FILL_W'(1);
    if (fill == LAST_IDX) begin
      if (!found) begin
        win_next[1] = wa[LAST];
        fill_next = REFILL;
      end else if (first_diff == FILL_W'(1)) begin
        for (int j = 2; j <= WINDOW; j++) begin
          win_next[j] = pick;
        end
        win_next[0] = pick;
        win_next[1] = wa[LAST];
        fill_next = REFILL;
      end else begin
        for (int s = 2; s <= WINDOW; s++) begin
          if (first_diff == FILL_W'(s)) begin
            for (int k = 0; k <= WLEN - s; k++) begin
              win_next[k] = wa[s - 1 + k];
            end
          end
        end
        fill_next = FILL_W'(WINDOW + 3) - first_diff;
      end
    end

    pair = 1'b0;
    for (int i = 1; i <= WINDOW; i++) begin
      if (win_next[i-1] == TREND_UP && win_next[i] == TREND_DOWN) begin
        pair = 1'b1;
      end
    end

    gap_inc = (gap == '1) ? gap : gap + AXIS_GAP_W'(1);
    hit = (fill_next == REFILL) && pair && (gap_inc > AXIS_GAP_W'(ctl.min_step_period));
    gap_next = hit ? '0 : gap_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: TREND_ZERO};
      fill <= '0;
      gap <= '0;
    end else if (ctl.advance) begin
      win <= win_next;
      fill <= fill_next;
      gap <= gap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prev <= sample;
    end
  end

endmodule
